### rtl/morse_text_encoder_defines.svh
// assertion macros for the morse text encoder checker
// no dependencies
`ifndef MORSE_TEXT_ENCODER_DEFINES_SVH
`define MORSE_TEXT_ENCODER_DEFINES_SVH

// implication checked at every rising clock edge outside reset
`define MTE_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication checked outside reset
`define MTE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/mte_pkg.sv
// shared types, codes and the morse lookup table of the text encoder
// no dependencies
package mte_pkg;

   localparam logic [2:0] SYM_DOT   = 3'd0;
   localparam logic [2:0] SYM_DASH  = 3'd1;
   localparam logic [2:0] SYM_GAP   = 3'd2;
   localparam logic [2:0] SYM_WORD  = 3'd3;
   localparam logic [2:0] SYM_ERROR = 3'd4;
   localparam logic [2:0] SYM_NONE  = 3'd5;

   localparam logic [1:0] KIND_CODE  = 2'd0;
   localparam logic [1:0] KIND_ERROR = 2'd1;
   localparam logic [1:0] KIND_NONE  = 2'd2;

   localparam logic [7:0] LEAD_BYTE = 8'hC3;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // symbol i of a code sits at bits[len-1-i], dash is one
   typedef struct packed {
      logic [2:0] len;
      logic [6:0] bits;
      logic       word;
   } code_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       gap;
      logic [2:0] len;
      logic [6:0] bits;
      logic       word;
      logic [7:0] bad;
      logic       last;
   } job_type;

   function automatic code_type mk(input logic [2:0] len, input logic [6:0] bits);
      code_type c;
      c.len  = len;
      c.bits = bits;
      c.word = 1'b0;
      return c;
   endfunction

   function automatic code_type morse_lookup(input logic [7:0] ch);
      code_type c;
      c = mk(3'd0, 7'b0);
      case (ch)
         "A": c = mk(3'd2, 7'b01);
         "B": c = mk(3'd4, 7'b1000);
         "C": c = mk(3'd4, 7'b1010);
         "D": c = mk(3'd3, 7'b100);
         "E": c = mk(3'd1, 7'b0);
         "F": c = mk(3'd4, 7'b0010);
         "G": c = mk(3'd3, 7'b110);
         "H": c = mk(3'd4, 7'b0000);
         "I": c = mk(3'd2, 7'b00);
         "J": c = mk(3'd4, 7'b0111);
         "K": c = mk(3'd3, 7'b101);
         "L": c = mk(3'd4, 7'b0100);
         "M": c = mk(3'd2, 7'b11);
         "N": c = mk(3'd2, 7'b10);
         "O": c = mk(3'd3, 7'b111);
         "P": c = mk(3'd4, 7'b0110);
         "Q": c = mk(3'd4, 7'b1101);
         "R": c = mk(3'd3, 7'b010);
         "S": c = mk(3'd3, 7'b000);
         "T": c = mk(3'd1, 7'b1);
         "U": c = mk(3'd3, 7'b001);
         "V": c = mk(3'd4, 7'b0001);
         "W": c = mk(3'd3, 7'b011);
         "X": c = mk(3'd4, 7'b1001);
         "Y": c = mk(3'd4, 7'b1011);
         "Z": c = mk(3'd4, 7'b1100);
         "0": c = mk(3'd5, 7'b11111);
         "1": c = mk(3'd5, 7'b01111);
         "2": c = mk(3'd5, 7'b00111);
         "3": c = mk(3'd5, 7'b00011);
         "4": c = mk(3'd5, 7'b00001);
         "5": c = mk(3'd5, 7'b00000);
         "6": c = mk(3'd5, 7'b10000);
         "7": c = mk(3'd5, 7'b11000);
         "8": c = mk(3'd5, 7'b11100);
         "9": c = mk(3'd5, 7'b11110);
         ".": c = mk(3'd6, 7'b010101);
         ",": c = mk(3'd6, 7'b110011);
         "?": c = mk(3'd6, 7'b001100);
         8'h27: c = mk(3'd6, 7'b011110);
         "!": c = mk(3'd6, 7'b101011);
         "/": c = mk(3'd5, 7'b10010);
         "(": c = mk(3'd5, 7'b10110);
         ")": c = mk(3'd6, 7'b101101);
         "&": c = mk(3'd5, 7'b01000);
         ":": c = mk(3'd6, 7'b111000);
         ";": c = mk(3'd6, 7'b101010);
         "=": c = mk(3'd5, 7'b10001);
         "+": c = mk(3'd5, 7'b01010);
         "-": c = mk(3'd6, 7'b100001);
         "_": c = mk(3'd6, 7'b001101);
         8'h22: c = mk(3'd6, 7'b010010);
         "$": c = mk(3'd7, 7'b0001001);
         "@": c = mk(3'd6, 7'b011010);
         " ": begin
            c = mk(3'd1, 7'b0);
            c.word = 1'b1;
         end
         default: c = mk(3'd0, 7'b0);
      endcase
      return c;
   endfunction

   function automatic logic [7:0] fold_accent(input logic [7:0] b);
      logic [7:0] r;
      case (b)
         8'hA0, 8'hA2, 8'hA4:        r = "A";
         8'hA7:                      r = "C";
         8'hA8, 8'hA9, 8'hAA, 8'hAB: r = "E";
         8'hAE, 8'hAF:               r = "I";
         8'hB4, 8'hB6:               r = "O";
         8'hB9, 8'hBB, 8'hBC:        r = "U";
         8'hBF:                      r = "Y";
         default:                    r = "?";
      endcase
      return r;
   endfunction

endpackage

### rtl/mte_front.sv
// front end: takes text bytes, tracks utf-8 lead and message state, classifies characters
// depends on mte_pkg
module mte_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_in_byte,
   input  logic             req_last_byte,
   input  logic             q_full,
   output logic             q_push,
   output mte_pkg::job_type q_job
);
   import mte_pkg::*;

   logic at_start_ff, at_start_in;
   logic lead_ff, lead_in;
   logic drop_ff, drop_in;
   logic accept;
   logic [7:0] ch;
   code_type code;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   always_comb begin
      at_start_in = at_start_ff;
      lead_in     = lead_ff;
      drop_in     = drop_ff;
      q_push      = 1'b0;
      ch          = (req_in_byte >= "a" && req_in_byte <= "z") ?
                    req_in_byte - 8'd32 : req_in_byte;
      if (lead_ff) begin
         ch = fold_accent(req_in_byte);
      end
      code        = morse_lookup(ch);
      q_job.kind  = KIND_CODE;
      q_job.gap   = !at_start_ff;
      q_job.len   = code.len;
      q_job.bits  = code.bits;
      q_job.word  = code.word;
      q_job.bad   = 8'd0;
      q_job.last  = req_last_byte;
      if (accept) begin
         if (drop_ff) begin
            if (req_last_byte) begin
               at_start_in = 1'b1;
               lead_in     = 1'b0;
               drop_in     = 1'b0;
            end
         end else if (!lead_ff && req_in_byte == LEAD_BYTE) begin
            if (req_last_byte) begin
               q_push      = 1'b1;
               q_job.kind  = KIND_NONE;
               at_start_in = 1'b1;
               lead_in     = 1'b0;
            end else begin
               lead_in = 1'b1;
            end
         end else begin
            q_push  = 1'b1;
            lead_in = 1'b0;
            if (code.len == 3'd0) begin
               q_job.kind = KIND_ERROR;
               q_job.bad  = ch;
               if (req_last_byte) begin
                  at_start_in = 1'b1;
               end else begin
                  drop_in = 1'b1;
               end
            end else begin
               at_start_in = req_last_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_start_ff <= 1'b1;
         lead_ff     <= 1'b0;
         drop_ff     <= 1'b0;
      end else begin
         at_start_ff <= at_start_in;
         lead_ff     <= lead_in;
         drop_ff     <= drop_in;
      end
   end

endmodule

### rtl/mte_fifo.sv
// short job queue between the front end and the symbol serializer
// depends on mte_pkg
module mte_fifo #(
   parameter int DEPTH = mte_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mte_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output mte_pkg::job_type head_job
);
   import mte_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   job_type       slot_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in;
   logic [PW-1:0] rd_ff, rd_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full     = (count_ff == FULL_COUNT);
   assign empty    = (count_ff == '0);
   assign head_job = slot_ff[rd_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == LAST_SLOT) ? '0 : wr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == LAST_SLOT) ? '0 : rd_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

endmodule

### rtl/mte_back.sv
// back end: walks a queued job one symbol per cycle into the result register while rsp_stall is low
// depends on mte_pkg
module mte_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  mte_pkg::job_type q_head,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [2:0]       rsp_symbol,
   output logic [7:0]       rsp_bad_char,
   output logic             rsp_run_end,
   output logic             rsp_message_end
);
   import mte_pkg::*;

   job_type    cur_ff, cur_in;
   logic       cur_valid_ff, cur_valid_in;
   logic [2:0] pos_ff, pos_in;
   logic       out_valid_ff, out_valid_in;
   logic [2:0] sym_ff, sym_in;
   logic [7:0] bad_ff, bad_in;
   logic       run_end_ff, run_end_in;
   logic       msg_end_ff, msg_end_in;
   logic       out_free, emit, final_beat;
   logic [3:0] total;
   logic [2:0] sym_pos, bit_idx;
   logic [7:0] bits8;

   assign out_free   = !out_valid_ff || !rsp_stall;
   assign emit       = cur_valid_ff && out_free;
   assign total      = {1'b0, cur_ff.len} + {3'b0, cur_ff.gap};
   assign final_beat = (cur_ff.kind != KIND_CODE) || ({1'b0, pos_ff} == total - 4'd1);
   assign sym_pos    = pos_ff - {2'b0, cur_ff.gap};
   assign bit_idx    = cur_ff.len - 3'd1 - sym_pos;
   assign bits8      = {1'b0, cur_ff.bits};
   assign q_pop      = !q_empty && (!cur_valid_ff || (emit && final_beat));

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      pos_in       = pos_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      sym_in       = sym_ff;
      bad_in       = bad_ff;
      run_end_in   = run_end_ff;
      msg_end_in   = msg_end_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         bad_in       = 8'd0;
         run_end_in   = final_beat;
         msg_end_in   = final_beat && cur_ff.last;
         case (cur_ff.kind)
            KIND_ERROR: begin
               sym_in     = SYM_ERROR;
               bad_in     = cur_ff.bad;
               msg_end_in = 1'b1;
            end
            KIND_NONE: sym_in = SYM_NONE;
            KIND_CODE: begin
               if (cur_ff.gap && pos_ff == 3'd0) begin
                  sym_in = SYM_GAP;
               end else if (cur_ff.word) begin
                  sym_in = SYM_WORD;
               end else begin
                  sym_in = bits8[bit_idx] ? SYM_DASH : SYM_DOT;
               end
            end
            default: sym_in = SYM_NONE;
         endcase
         if (final_beat) begin
            cur_valid_in = 1'b0;
         end else begin
            pos_in = pos_ff + 3'd1;
         end
      end
      if (q_pop) begin
         cur_in       = q_head;
         cur_valid_in = 1'b1;
         pos_in       = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         pos_ff       <= 3'd0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      sym_ff     <= sym_in;
      bad_ff     <= bad_in;
      run_end_ff <= run_end_in;
      msg_end_ff <= msg_end_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_symbol      = sym_ff;
   assign rsp_bad_char    = bad_ff;
   assign rsp_run_end     = run_end_ff;
   assign rsp_message_end = msg_end_ff;

endmodule

### rtl/morse_text_encoder.sv
// morse text encoder top level: front end, job queue, symbol serializer
// path: the first result of an accepted byte passes the queue slot, the serializer job register and the result register
// results: one result per cycle from the serializer while rsp_stall is low, so a character gives a gap (not at
// message start) and then its symbols; bytes that give no result stop in the front end
// reset: synchronous active high, empties queue and serializer and starts a new message
module morse_text_encoder #(
   parameter int QUEUE_DEPTH = mte_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_symbol,
   output logic [7:0] rsp_bad_char,
   output logic       rsp_run_end,
   output logic       rsp_message_end
);
   import mte_pkg::*;

   job_type push_job, head_job;
   logic    push, full, pop, empty;

   mte_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_byte   (req_in_byte),
      .req_last_byte (req_last_byte),
      .q_full        (full),
      .q_push        (push),
      .q_job         (push_job)
   );

   mte_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (full),
      .pop      (pop),
      .empty    (empty),
      .head_job (head_job)
   );

   mte_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (empty),
      .q_head          (head_job),
      .q_pop           (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_symbol      (rsp_symbol),
      .rsp_bad_char    (rsp_bad_char),
      .rsp_run_end     (rsp_run_end),
      .rsp_message_end (rsp_message_end)
   );

endmodule

### rtl/mte_checker.sv
// port-level checks on the morse text encoder result channel, bound to the top level
// depends on mte_pkg and morse_text_encoder_defines.svh
`include "morse_text_encoder_defines.svh"

module mte_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_symbol,
   input logic [7:0] rsp_bad_char,
   input logic       rsp_run_end,
   input logic       rsp_message_end
);
   import mte_pkg::*;

   `MTE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable({rsp_symbol, rsp_bad_char, rsp_run_end, rsp_message_end}), "stalled result beat changed")
   `MTE_ASSERT_IMPLY(a_msg_end_run_end, clock, reset, rsp_valid && rsp_message_end, rsp_run_end, "message end without run end")
   `MTE_ASSERT_IMPLY(a_bad_char_zero, clock, reset, rsp_valid && rsp_symbol != SYM_ERROR, rsp_bad_char == 8'd0, "bad char set outside error")
   `MTE_ASSERT_IMPLY(a_single_ends, clock, reset, rsp_valid && (rsp_symbol == SYM_ERROR || rsp_symbol == SYM_NONE), rsp_run_end && rsp_message_end, "error or none beat does not close the message")

endmodule

bind morse_text_encoder mte_checker u_mte_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_symbol      (rsp_symbol),
   .rsp_bad_char    (rsp_bad_char),
   .rsp_run_end     (rsp_run_end),
   .rsp_message_end (rsp_message_end)
);
